### hdl/bmap_pkg.sv
package bmap_pkg;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;
  localparam logic [1:0] REQ_TEST   = 2'd3;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned WIDX_W  = 6;
  localparam logic [CNT_W-1:0] BIT_COUNT_RST = 13'd4096;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] first_bit;
    logic [IDX_W-1:0] last_bit;
  } bmap_req_t;

  typedef struct packed {
    logic status;
    logic bit_value;
  } bmap_rsp_t;

endpackage

### hdl/bmap_ram.sv
module bmap_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/bitmap_range_set_clear_toggle.sv
// Bitmap of MAP_WORDS 64-bit words with range set, clear and toggle and a
// single-bit test. Bit i lives in word i/64, position i%64.
// Input channel (in_valid/in_stall, in_req): one request, a request type and
// a first and last bit index. Result channel (out_valid/out_stall, out_rsp):
// one status/bit_value response per request, in request order.
// Configuration (cfg_valid/cfg_ready, cfg_data): the bit count used for
// bounds checking; cfg_ready is always high.
// Timing: a request is taken only when the engine is idle. Word updates are
// read-modify-write through one registered-read memory port, one word per
// cycle, so a request spanning N words updates them in order and loads the
// response register when the last word is written; tests read one word and
// answer from it, and rejected requests are answered without a memory read.
// Reset: the bit count returns to 4096 and the memory is swept to zero,
// one word per cycle, over all MAP_WORDS words; in_stall is high meanwhile.
// A stalled response holds in the output register; a request that
// finishes behind it waits until that register empties.
module bitmap_range_set_clear_toggle #(
  parameter int unsigned MAP_WORDS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bmap_pkg::bmap_req_t              in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bmap_pkg::bmap_rsp_t              out_rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmap_pkg::CNT_W-1:0]       cfg_data
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [bmap_pkg::CNT_W:0] CAP_C =
    (MAP_WORDS * 64 > 8191) ? 14'd8191 : 14'(MAP_WORDS * 64);

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [1:0]                           op_r, op_nxt;
  logic [bmap_pkg::IDX_W-1:0]           first_r, first_nxt;
  logic [bmap_pkg::IDX_W-1:0]           last_r, last_nxt;
  logic [bmap_pkg::WIDX_W-1:0]          cur_w_r, cur_w_nxt;
  logic [AW-1:0]                        clr_addr_r, clr_addr_nxt;
  logic [bmap_pkg::CNT_W-1:0]           bit_count_r;
  logic                                 out_valid_r, out_valid_nxt;
  bmap_pkg::bmap_rsp_t                  out_rsp_r, out_rsp_nxt;
  bmap_pkg::bmap_rsp_t                  pend_r, pend_nxt;

  logic                                 ram_we, ram_re;
  logic [AW-1:0]                        ram_waddr, ram_raddr;
  logic [bmap_pkg::WORD_W-1:0]          ram_wdata, ram_rdata;

  logic                                 in_accept;
  logic                                 out_free;
  logic [bmap_pkg::CNT_W:0]             limit;
  logic                                 first_bad, last_bad, req_err;
  logic [bmap_pkg::WORD_W-1:0]          lo_mask, hi_mask, mask, new_word;
  bmap_pkg::bmap_rsp_t                  done_rsp;
  logic                                 finish;

  bmap_ram #(
    .WIDTH (bmap_pkg::WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // usable bits: smaller of bit count and storage
  assign limit = ({1'b0, bit_count_r} < CAP_C) ? {1'b0, bit_count_r} : CAP_C;

  always_comb begin
    first_bad = ({2'b00, in_req.first_bit} >= limit);
    last_bad  = ({2'b00, in_req.last_bit} >= limit);
    if (in_req.req_type == bmap_pkg::REQ_TEST) begin
      req_err = first_bad;
    end else begin
      req_err = first_bad || last_bad || (in_req.first_bit > in_req.last_bit);
    end
  end

  always_comb begin
    lo_mask = {bmap_pkg::WORD_W{1'b1}} << first_r[5:0];
    hi_mask = {bmap_pkg::WORD_W{1'b1}} >> (~last_r[5:0]);
    mask    = ((cur_w_r == first_r[11:6]) ? lo_mask : {bmap_pkg::WORD_W{1'b1}}) &
              ((cur_w_r == last_r[11:6])  ? hi_mask : {bmap_pkg::WORD_W{1'b1}});
    case (op_r)
      bmap_pkg::REQ_SET:    new_word = ram_rdata | mask;
      bmap_pkg::REQ_CLEAR:  new_word = ram_rdata & ~mask;
      bmap_pkg::REQ_TOGGLE: new_word = ram_rdata ^ mask;
      default:              new_word = ram_rdata;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    cur_w_nxt     = cur_w_r;
    clr_addr_nxt  = clr_addr_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(cur_w_r);
    ram_wdata     = new_word;
    ram_re        = 1'b0;
    ram_raddr     = AW'(in_req.first_bit[11:6]);
    done_rsp      = '0;
    finish        = 1'b0;

    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_req.req_type;
          first_nxt = in_req.first_bit;
          last_nxt  = in_req.last_bit;
          cur_w_nxt = in_req.first_bit[11:6];
          if (req_err) begin
            done_rsp.status = 1'b1;
            finish          = 1'b1;
          end else begin
            ram_re    = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (op_r == bmap_pkg::REQ_TEST) begin
          done_rsp.bit_value = ram_rdata[first_r[5:0]];
          finish             = 1'b1;
        end else begin
          ram_we = 1'b1;
          if (cur_w_r == last_r[11:6]) begin
            finish = 1'b1;
          end else begin
            cur_w_nxt = cur_w_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = AW'(cur_w_r + 1'b1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = pend_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = done_rsp;
        state_nxt     = ST_IDLE;
      end else begin
        pend_nxt  = done_rsp;
        state_nxt = ST_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      bit_count_r <= bmap_pkg::BIT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bit_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    cur_w_r   <= cur_w_nxt;
    pend_r    <= pend_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule
